### sv/mono_bitmap_run_extractor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for mono_bitmap_run_extractor
// Short wrappers for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_RUN_EXTRACTOR_ASSERT_SVH
`define MONO_BITMAP_RUN_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define MBRE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbre assertion failed");

// next-cycle implication
`define MBRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbre assertion failed");

`endif

### sv/mbre_pkg.sv
// ----------------------------------------------------------------------------
// mbre_pkg
// Shared types and constants of the 1bpp bitmap run extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbre_pkg;

  localparam int unsigned MAX_RUNS  = 5;
  localparam int unsigned ROW_LIMIT = 4096;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  byte_position;
    logic [11:0] row_counter;
    logic        inside_run;
    logic [11:0] open_run_first;
  } scan_state_t;

  typedef struct packed {
    logic [2:0]                 count;
    logic [11:0]                row;
    logic [MAX_RUNS-1:0][11:0]  first;
    logic [MAX_RUNS-1:0][12:0]  stop;
  } run_set_t;

endpackage

### sv/mbre_scan.sv
// ----------------------------------------------------------------------------
// mbre_scan
// Scans one pixel byte against the running row state, lists the runs it
// closes and computes the state after the byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbre_scan (
  input  logic [7:0]           pixel_byte,
  input  logic                 image_start,
  input  logic [12:0]          width,
  input  logic [12:0]          height,
  input  mbre_pkg::scan_state_t state,
  output mbre_pkg::scan_state_t state_next,
  output mbre_pkg::run_set_t    runs
);
  import mbre_pkg::*;

  scan_state_t cur;
  logic [10:0] nbytes;
  logic [10:0] stride;
  logic [13:0] width_sum;
  logic [10:0] nbytes_sum;
  logic        byte_live;
  logic [10:0] bp_inc;
  logic [12:0] row_inc;

  always_comb begin
    cur = state;
    if (image_start) begin
      cur = '0;
    end
    width_sum  = {1'b0, width} + 14'd7;
    nbytes     = width_sum[13:3];
    nbytes_sum = nbytes + 11'd3;
    stride     = {nbytes_sum[10:2], 2'b00};
    byte_live  = {1'b0, cur.byte_position} < nbytes;
  end

  always_comb begin
    logic        in_run;
    logic [11:0] first_col;
    logic [2:0]  cnt;
    logic [12:0] col;
    in_run    = cur.inside_run;
    first_col = cur.open_run_first;
    cnt       = '0;
    runs      = '0;
    runs.row  = cur.row_counter;
    for (int b = 0; b < 8; b++) begin
      col = {cur.byte_position, 3'(b)};
      if (byte_live && (col < width)) begin
        if (pixel_byte[3'(7 - b)] && !in_run) begin
          in_run    = 1'b1;
          first_col = col[11:0];
        end else if (!pixel_byte[3'(7 - b)] && in_run) begin
          runs.first[cnt] = first_col;
          runs.stop[cnt]  = col;
          cnt             = cnt + 3'd1;
          in_run          = 1'b0;
        end
      end
    end
    if (byte_live && (bp_inc == nbytes) && in_run) begin
      runs.first[cnt] = first_col;
      runs.stop[cnt]  = width;
      cnt             = cnt + 3'd1;
      in_run          = 1'b0;
    end
    runs.count = cnt;

    state_next                = cur;
    state_next.inside_run     = in_run;
    state_next.open_run_first = first_col;
    if (bp_inc >= stride) begin
      state_next.byte_position = '0;
      state_next.inside_run    = 1'b0;
      if (row_inc >= height) begin
        state_next.row_counter = '0;
      end else begin
        state_next.row_counter = row_inc[11:0];
      end
    end else begin
      state_next.byte_position = bp_inc[9:0];
    end
  end

  assign bp_inc  = {1'b0, cur.byte_position} + 11'd1;
  assign row_inc = {1'b0, cur.row_counter} + 13'd1;

endmodule

### sv/mbre_runbuf.sv
// ----------------------------------------------------------------------------
// mbre_runbuf
// Holds the runs of one byte and hands them out one beat at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbre_runbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mbre_pkg::run_set_t  runs,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         run_row,
  output logic [11:0]         run_first,
  output logic [12:0]         run_stop,
  output logic                last_of_byte
);
  import mbre_pkg::*;

  run_set_t   held;
  logic [2:0] cnt;
  logic [2:0] rd;
  logic [2:0] rd_next;
  logic       is_last;
  logic       take;

  assign rd_next      = rd + 3'd1;
  assign is_last      = (rd_next == cnt);
  assign out_valid    = (cnt != 3'd0);
  assign take         = out_valid && !out_stall;
  assign can_load     = !out_valid || (take && is_last);
  assign run_row      = held.row;
  assign run_first    = held.first[rd];
  assign run_stop     = held.stop[rd];
  assign last_of_byte = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= runs.count;
      rd  <= '0;
    end else if (take) begin
      if (is_last) begin
        cnt <= '0;
        rd  <= '0;
      end else begin
        rd <= rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= runs;
    end
  end

endmodule

### sv/mono_bitmap_run_extractor.sv
// ----------------------------------------------------------------------------
// mono_bitmap_run_extractor
// Run extractor for a 1bpp bitmap stream, one pixel byte per beat, rows
// padded to a 4-byte stride. Emits row, first column and stop column of
// every maximal run of set pixels.
// Output: a byte's first run appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while bytes close at most one run and
// out_stall is low; a byte closing n runs occupies the run buffer for n
// output beats (n up to 5). Reset: rst (synchronous) clears position, row
// and run state, empties the run buffer and sets width to 8 and height to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mono_bitmap_run_extractor_assert.svh"

module mono_bitmap_run_extractor #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] run_row,
  output logic [11:0] run_first,
  output logic [12:0] run_stop,
  output logic        last_of_byte
);
  import mbre_pkg::*;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [12:0] width_eff;
  logic [12:0] height_eff;
  scan_state_t state;
  scan_state_t state_next;
  run_set_t    runs;
  logic        can_load;
  logic        in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd8;
      image_height <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = image_width;
    if (image_width == 13'd0) begin
      width_eff = 13'd1;
    end else if ({4'd0, image_width} > 17'(MAX_WIDTH)) begin
      width_eff = 13'(MAX_WIDTH);
    end
    height_eff = image_height;
    if (image_height == 13'd0) begin
      height_eff = 13'd1;
    end else if (image_height > 13'(ROW_LIMIT)) begin
      height_eff = 13'(ROW_LIMIT);
    end
  end

  assign in_stall = !can_load;
  assign in_take  = in_valid && can_load;

  mbre_scan u_scan (
    .pixel_byte (pixel_byte),
    .image_start(image_start),
    .width      (width_eff),
    .height     (height_eff),
    .state      (state),
    .state_next (state_next),
    .runs       (runs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  mbre_runbuf u_runbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (in_take),
    .runs        (runs),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .run_row     (run_row),
    .run_first   (run_first),
    .run_stop    (run_stop),
    .last_of_byte(last_of_byte)
  );

  `MBRE_ASSERT_IMPLY(a_take_when_drained, clk, rst, in_valid && !in_stall, !out_valid || (!out_stall && last_of_byte))
  `MBRE_ASSERT_NEXT(a_same_row_in_byte, clk, rst, out_valid && !out_stall && !last_of_byte, out_valid && $stable(run_row))
  `MBRE_ASSERT_IMPLY(a_stop_after_first, clk, rst, out_valid, run_stop > {1'b0, run_first})

endmodule
